FILE: hdl/assert_macros.svh
// assertion macros for the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: hdl/wsr_pkg.sv
// shared types and constants for the windowed sinc resampler
package wsr_pkg;

	// operation codes of an input word
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_INTERP = 2'd1;
	localparam logic [1:0] OP_TWRITE = 2'd2;

	// width of the tap number carried in a command (covers up to 64 taps)
	localparam int TAP_NUM_W = 6;

	typedef struct packed {
		logic [1:0]          operation;
		logic signed [15:0]  sample_in;
		logic [10:0]         table_index;
		logic signed [15:0]  table_value;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0]  sample_out;
		logic                clipped;
	} out_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic                 push;
		logic                 twrite;
		logic                 start;
		logic                 issue;
		logic                 finish;
		logic [TAP_NUM_W-1:0] tap;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic pipe_empty;
		logic out_full;
	} dp_stat_t;

endpackage

FILE: hdl/wsr_datapath.sv
// datapath: delay line, kernel memory, phase, tap pipeline, accumulator, output register
module wsr_datapath #(
	parameter int TAPS        = 16,
	parameter int TABLE_RESO  = 256,
	parameter int TABLE_DEPTH = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wsr_pkg::dp_cmd_t   cmd,
	output wsr_pkg::dp_stat_t  stat,
	input  wsr_pkg::in_word_t  in_data,
	input  logic               cfg_valid,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output wsr_pkg::out_word_t out_data
);
	import wsr_pkg::*;

	localparam int TW    = $clog2(TAPS);
	localparam int DW    = 32 + TW + 2;
	localparam int RSW   = $clog2(TABLE_RESO + 1);
	localparam int MW    = DW - 1 + RSW;
	localparam int HW    = MW - 32;
	localparam int CW    = HW + 17;
	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int ACC_W = 32 + TW + 1;
	localparam int QW    = ACC_W - 15;
	localparam logic [DW-1:0] CENTER_OFFS = DW'(TAPS) << 31;
	localparam logic signed [QW-1:0] SAT_MAX = QW'(32767);
	localparam logic signed [QW-1:0] SAT_MIN = QW'(-32768);

	logic [31:0]              phase_step_q;
	logic [31:0]              phase_q;
	logic signed [15:0]       dl_q [TAPS];
	logic signed [15:0]       kernel_mem_q [TABLE_DEPTH];

	logic [DW-1:0]            dist_c;
	logic [DW-1:0]            mag_c;
	logic [MW-1:0]            scaled_c;
	logic [HW-1:0]            scaled_hi_c;
	logic [AW-1:0]            idx_c;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [DW-2:0]            mag_s1;
	logic signed [15:0]       samp_s1, samp_s2, samp_s3;
	logic [AW-1:0]            idx_s2;
	logic signed [15:0]       coef_s3;
	logic signed [31:0]       prod_s4;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [ACC_W-1:0]  rnd_c;
	logic signed [QW-1:0]     quot_c;
	out_word_t                res_c;
	logic                     out_valid_q;
	out_word_t                out_q;

	// phase step register and phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			phase_q      <= '0;
		end else begin
			if (cfg_valid)
				phase_step_q <= cfg_data;
			if (cmd.start)
				phase_q <= phase_q + phase_step_q;
		end
	end

	// delay line: shift on push, rotate by one per issued tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TAPS; j++)
				dl_q[j] <= '0;
		end else if (cmd.push) begin
			for (int j = 0; j < TAPS - 1; j++)
				dl_q[j] <= dl_q[j+1];
			dl_q[TAPS-1] <= in_data.sample_in;
		end else if (cmd.issue) begin
			for (int j = 0; j < TAPS - 1; j++)
				dl_q[j] <= dl_q[j+1];
			dl_q[TAPS-1] <= dl_q[0];
		end
	end

	// kernel memory write port
	always_ff @(posedge clk) begin
		if (cmd.twrite && (32'(in_data.table_index) < 32'(TABLE_DEPTH)))
			kernel_mem_q[AW'(in_data.table_index)] <= in_data.table_value;
	end

	// stage 1: signed distance of the tap from the phase point, then magnitude
	always_comb begin
		dist_c = ((DW'(cmd.tap) + DW'(1)) << 32) - CENTER_OFFS - DW'(phase_q);
		mag_c  = dist_c[DW-1] ? (~dist_c + DW'(1)) : dist_c;
	end

	// stage 2: scale to table resolution and clamp to the last entry
	always_comb begin
		scaled_c    = MW'(mag_s1) * MW'(TABLE_RESO);
		scaled_hi_c = scaled_c[MW-1:32];
		if (CW'(scaled_hi_c) > CW'(TABLE_DEPTH - 1))
			idx_c = AW'(TABLE_DEPTH - 1);
		else
			idx_c = AW'(scaled_hi_c);
	end

	// tap pipeline: index, memory read, multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag_c[DW-2:0];
		samp_s1 <= dl_q[0];
		idx_s2  <= idx_c;
		samp_s2 <= samp_s1;
		coef_s3 <= kernel_mem_q[idx_s2];
		samp_s3 <= samp_s2;
		prod_s4 <= samp_s3 * coef_s3;
	end

	// accumulator, cleared when an interpolation starts
	always_ff @(posedge clk) begin
		if (cmd.start)
			acc_q <= '0;
		else if (v_s4)
			acc_q <= acc_q + ACC_W'(prod_s4);
	end

	// round half up, drop 15 fraction bits, saturate to 16 bits
	always_comb begin
		rnd_c  = acc_q + ACC_W'(16384);
		quot_c = $signed(rnd_c[ACC_W-1:15]);
		if (quot_c > SAT_MAX) begin
			res_c.sample_out = 16'sd32767;
			res_c.clipped    = 1'b1;
		end else if (quot_c < SAT_MIN) begin
			res_c.sample_out = -16'sd32768;
			res_c.clipped    = 1'b1;
		end else begin
			res_c.sample_out = quot_c[15:0];
			res_c.clipped    = 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish)
			out_q <= res_c;
	end

	// status and outputs
	assign stat.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign stat.out_full   = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

FILE: hdl/wsr_ctrl.sv
// controller: input handshake, tap sequencing, result hand-off
`include "assert_macros.svh"

module wsr_ctrl #(
	parameter int TAPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	output wsr_pkg::dp_cmd_t  cmd,
	input  wsr_pkg::dp_stat_t stat
);
	import wsr_pkg::*;

	localparam int TW = $clog2(TAPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t        state_q;
	logic [TW-1:0] tap_q;
	logic          accept;

	// command decode
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		accept     = in_valid && in_ready;
		cmd.push   = accept && (op == OP_PUSH);
		cmd.twrite = accept && (op == OP_TWRITE);
		cmd.start  = accept && (op == OP_INTERP);
		cmd.issue  = (state_q == ST_RUN);
		cmd.tap    = TAP_NUM_W'(tap_q);
		cmd.finish = (state_q == ST_DRAIN) && stat.pipe_empty && !stat.out_full;
	end

	// state and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					tap_q <= '0;
					if (cmd.start)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (tap_q == TW'(TAPS - 1)) begin
						tap_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						tap_q <= tap_q + TW'(1);
					end
				end
				ST_DRAIN: begin
					if (cmd.finish)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
					tap_q   <= '0;
				end
			endcase
		end
	end

	// the tap pipeline is empty whenever a new word can be taken
	`ASSERT_IMPLY(a_idle_pipe_empty, state_q == ST_IDLE, stat.pipe_empty)
	// an interpolation starts at tap zero
	`ASSERT_NEXT(a_start_runs, cmd.start, (state_q == ST_RUN) && (tap_q == '0))
	// the last tap moves the sequencer to drain
	`ASSERT_NEXT(a_last_tap_drains, (state_q == ST_RUN) && (tap_q == TW'(TAPS - 1)),
		state_q == ST_DRAIN)

endmodule

FILE: hdl/windowed_sinc_resampler.sv
// top level of the windowed sinc resampler
//
// Input channel in_valid/in_ready/in_data carries one word per handshake:
// push (shift a sample into the TAPS-deep delay line), table write (load one
// Q1.15 kernel coefficient) or interpolate (advance the phase by phase_step
// and produce one output word). Unknown operations are taken and dropped.
// Config channel cfg_valid/cfg_ready/cfg_data writes phase_step; it is always
// ready and is to be written only while the block is idle.
// Push and table write leave in_ready high, so such words can be taken back
// to back. An interpolate word runs one shared multiply-accumulate over the
// taps, one tap per cycle, through a four-stage index/read/multiply pipeline;
// in_ready is low until its result is loaded into the output register.
// Output channel out_valid/out_ready/out_data holds the result in a register;
// push and table-write words are still taken while it waits. If the receiver
// stalls, a following interpolation finishes its taps and holds until the
// register is taken.
// Reset clears phase, phase_step and delay line; the kernel memory is not
// cleared and must be written before use.
module windowed_sinc_resampler #(
	parameter int TAPS        = 16,
	parameter int TABLE_RESO  = 256,
	parameter int TABLE_DEPTH = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wsr_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output wsr_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);
	import wsr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// config register is always writable
	assign cfg_ready = 1'b1;

	// sequencer
	wsr_ctrl #(
		.TAPS (TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (in_data.operation),
		.cmd      (cmd),
		.stat     (stat)
	);

	// datapath
	wsr_datapath #(
		.TAPS        (TAPS),
		.TABLE_RESO  (TABLE_RESO),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: tb/windowed_sinc_resampler_tb.sv
// self-checking testbench for the windowed sinc resampler
`timescale 1ns / 100ps

module windowed_sinc_resampler_tb;
	import wsr_pkg::*;

	localparam int TAPS        = 16;
	localparam int TABLE_RESO  = 256;
	localparam int TABLE_DEPTH = 2048;

	// operation code the block takes and drops
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// cycles to let pass after the last output so pushes and writes settle
	localparam int SETTLE_CYCLES = TAPS + 10;
	// length of the long receiver hold-off
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 125;
	localparam int MAX_PRINTED = 100;
	// table entries per sixteenth of a tap distance
	localparam int GRID_STEP = TABLE_RESO / 16;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t want;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_word_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;

	// predictor state
	logic signed [15:0] delay_q [TAPS];
	logic signed [15:0] coef_mem [TABLE_DEPTH];
	logic [31:0]        phase_q;
	logic [31:0]        step_q;

	out_word_t pending_outputs [$];

	int  mismatches      = 0;
	int  outputs_checked = 0;
	int  clipped_seen    = 0;
	int  words_sent      = 0;
	int  step_settings   = 0;
	bit  no_idle         = 1'b0;
	int  long_hold_reqs  = 0;

	windowed_sinc_resampler #(
		.TAPS        (TAPS),
		.TABLE_RESO  (TABLE_RESO),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	always #5 clk = ~clk;

	// run limit
	initial begin
		#5000000;
		$display("FAIL windowed_sinc_resampler");
		$finish;
	end

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// fixed-point model of one input word
	function automatic void resample_word(in_word_t w, output bit has_out,
			output out_word_t res);
		longint acc;
		longint tap_dist;
		longint mag;
		longint idx;
		longint r;
		has_out = 1'b0;
		res = '0;
		case (w.operation)
			OP_PUSH: begin
				for (int k = 0; k < TAPS - 1; k++)
					delay_q[k] = delay_q[k + 1];
				delay_q[TAPS - 1] = w.sample_in;
			end
			OP_TWRITE: begin
				if (int'(w.table_index) < TABLE_DEPTH)
					coef_mem[w.table_index] = w.table_value;
			end
			OP_INTERP: begin
				phase_q = phase_q + step_q;
				acc = 0;
				for (int k = 0; k < TAPS; k++) begin
					// distance from tap to phase in Q.32
					tap_dist = longint'(k) * 64'sd4294967296
						- longint'(TAPS) * 64'sd2147483648
						+ 64'sd4294967296 - longint'(phase_q);
					mag = (tap_dist < 0) ? -tap_dist : tap_dist;
					idx = (mag * TABLE_RESO) >>> 32;
					if (idx > TABLE_DEPTH - 1)
						idx = TABLE_DEPTH - 1;
					acc += longint'(delay_q[k]) * longint'(coef_mem[idx]);
				end
				// round half up, then saturate
				r = (acc + 16384) >>> 15;
				res.clipped = 1'b0;
				if (r > 32767) begin
					r = 32767;
					res.clipped = 1'b1;
				end else if (r < -32768) begin
					r = -32768;
					res.clipped = 1'b1;
				end
				res.sample_out = r[15:0];
				has_out = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// offer one word and record what it should produce
	task automatic send_word(in_word_t w, bit typed, out_word_t want);
		bit        has_out;
		out_word_t predicted;
		int        gap;
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		resample_word(w, has_out, predicted);
		if (has_out)
			pending_outputs.push_back(typed ? want : predicted);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_outputs_done();
		while (pending_outputs.size() != 0)
			@(posedge clk);
	endtask

	// write phase_step with the block idle
	task automatic write_step(logic [31:0] v);
		in_valid <= 1'b0;
		wait_outputs_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		step_q = v;
		step_settings++;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] shaped_value();
		logic signed [15:0] v;
		v = 16'($urandom);
		if ($urandom_range(0, 1) == 1)
			v = v >>> $urandom_range(1, 4);
		return v;
	endfunction

	// load the entries the run reads: flat full scale on the whole-tap grid and the
	// last entry, or random shaped values on both sides of every sixteenth of a tap
	task automatic load_kernel(bit random_vals);
		in_word_t w;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (random_vals ? (i % GRID_STEP == 0 || i % GRID_STEP == GRID_STEP - 1)
					: (i % TABLE_RESO == 0 || i == TABLE_DEPTH - 1)) begin
				w.operation   = OP_TWRITE;
				w.sample_in   = 16'($urandom);
				w.table_index = 11'(i);
				w.table_value = random_vals ? shaped_value() : 16'sh7FFF;
				send_word(w, 1'b0, '0);
			end
		end
	endtask

	function automatic in_word_t random_word();
		in_word_t w;
		int       r;
		r = $urandom_range(0, 99);
		if (r < 45)
			w.operation = OP_PUSH;
		else if (r < 80)
			w.operation = OP_INTERP;
		else if (r < 95)
			w.operation = OP_TWRITE;
		else
			w.operation = OP_UNUSED;
		w.sample_in   = shaped_value();
		w.table_index = 11'($urandom);
		w.table_value = shaped_value();
		return w;
	endfunction

	// one stretch of random words at a fixed phase_step
	task automatic run_phase(int n_words, int hold_at, int pause_at);
		in_word_t w;
		int       sent;
		bit       hold_done;
		bit       pause_done;
		sent = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		while (sent < n_words) begin
			w = random_word();
			send_word(w, 1'b0, '0);
			if (w.operation != OP_UNUSED)
				sent++;
			if (sent == hold_at && !hold_done) begin
				long_hold_reqs++;
				hold_done = 1'b1;
			end
			if (sent == pause_at && !pause_done) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait_outputs_done();
				pause_done = 1'b1;
			end
		end
	endtask

	function automatic dir_row_t dir_row(logic [1:0] op, int smp, int idx, int val,
			bit typed = 1'b0, int want_s = 0, bit want_c = 1'b0);
		dir_row_t r;
		r.w.operation   = op;
		r.w.sample_in   = smp[15:0];
		r.w.table_index = idx[10:0];
		r.w.table_value = val[15:0];
		r.typed           = typed;
		r.want.sample_out = want_s[15:0];
		r.want.clipped    = want_c;
		return r;
	endfunction

	// output side: check each word taken, stall in bursts
	initial begin
		int        stall_left;
		int        long_left;
		int        long_seen;
		out_word_t want;
		stall_left = 0;
		long_left  = 0;
		long_seen  = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_outputs.size() == 0) begin
					report_mismatch($sformatf("output word %0d with nothing pending",
						out_data.sample_out));
				end else begin
					want = pending_outputs.pop_front();
					if (out_data.sample_out !== want.sample_out)
						report_mismatch($sformatf("sample_out got %0d want %0d",
							out_data.sample_out, want.sample_out));
					if (out_data.clipped !== want.clipped)
						report_mismatch($sformatf("clipped got %0b want %0b",
							out_data.clipped, want.clipped));
					if (want.clipped)
						clipped_seen++;
					outputs_checked++;
				end
			end
			if (long_seen != long_hold_reqs) begin
				long_seen = long_hold_reqs;
				long_left = LONG_HOLD_CYCLES;
			end
			if (long_left > 0) begin
				long_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// main sequence
	initial begin
		dir_row_t    rows [$];
		logic [31:0] steps [6];
		for (int k = 0; k < TAPS; k++)
			delay_q[k] = '0;
		phase_q = '0;
		step_q  = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flat full-scale kernel so the directed outputs are easy to read
		load_kernel(1'b0);

		// at reset phase and step are zero: taps read entries |k-7|*256, the last one clamped
		rows.push_back(dir_row(OP_INTERP, 0, 0, 0, 1'b1, 0, 1'b0));
		rows.push_back(dir_row(OP_TWRITE, 0, 2047, 16'h4000));
		rows.push_back(dir_row(OP_PUSH, 1, 0, 0));
		// exact half rounds up
		rows.push_back(dir_row(OP_INTERP, 0, 0, 0, 1'b1, 1, 1'b0));
		rows.push_back(dir_row(OP_PUSH, -1, 0, 0));
		rows.push_back(dir_row(OP_INTERP, 0, 0, 0));
		rows.push_back(dir_row(OP_TWRITE, 0, 2047, 16'h7FFF));
		rows.push_back(dir_row(OP_PUSH, 32767, 0, 0));
		rows.push_back(dir_row(OP_PUSH, 32767, 0, 0));
		// positive saturation
		rows.push_back(dir_row(OP_INTERP, 0, 0, 0, 1'b1, 32767, 1'b1));
		rows.push_back(dir_row(OP_TWRITE, 0, 1792, 16'h8000));
		rows.push_back(dir_row(OP_TWRITE, 0, 2047, 16'h8000));
		// negative saturation
		rows.push_back(dir_row(OP_INTERP, 0, 0, 0, 1'b1, -32768, 1'b1));
		rows.push_back(dir_row(OP_PUSH, -32768, 0, 0));
		rows.push_back(dir_row(OP_TWRITE, -1, 0, 0));
		// unknown operation is dropped
		rows.push_back(dir_row(OP_UNUSED, $urandom, $urandom, $urandom));
		rows.push_back(dir_row(OP_INTERP, 0, 0, 0));
		rows.push_back(dir_row(OP_UNUSED, -1, 2047, -1));
		rows.push_back(dir_row(OP_TWRITE, 0, 1792, 16'h7FFF));
		rows.push_back(dir_row(OP_INTERP, 0, 2047, -1));
		foreach (rows[i])
			send_word(rows[i].w, rows[i].typed, rows[i].want);

		// random kernel for the random part
		load_kernel(1'b1);

		// steps keep the phase on sixteenths or drift it by far less than one
		// table entry, so only loaded entries are read
		steps[0] = 32'hFFFF_FFFF;
		steps[1] = 32'h8000_0000;
		steps[2] = {4'($urandom_range(1, 15)), 28'h0};
		steps[3] = $urandom_range(1, 65535);
		steps[4] = 32'h0000_0000;
		steps[5] = {4'($urandom_range(1, 15)), 28'h0};
		for (int p = 0; p < 6; p++) begin
			write_step(steps[p]);
			if (p == 5)
				no_idle = 1'b1;
			run_phase(PHASE_WORDS, (p == 2) ? 60 : -1, (p == 3) ? 100 : -1);
		end
		in_valid <= 1'b0;

		// drain
		wait_outputs_done();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("words sent %0d, outputs checked %0d (%0d saturated), phase_step settings %0d",
			words_sent, outputs_checked, clipped_seen, step_settings);
		$display("covered extremes, rounding, saturation, dropped codes, long output stall");
		if (mismatches == 0) begin
			$display("PASS windowed_sinc_resampler");
		end else begin
			$display("FAIL windowed_sinc_resampler");
		end
		$finish;
	end

endmodule
